// File: sv/lobm_pkg.sv
package lobm_pkg;

  // widest slot index the book can need (BOOK_DEPTH up to 1024)
  localparam int IDX_W = 10;
  localparam int PRC_W = 32;
  localparam int VOL_W = 32;
  localparam int NUM_W = 32;
  localparam int ARR_W = 40;
  localparam int SUM_W = 36;

  typedef enum logic [2:0] {
    ACT_BUY    = 3'd0,
    ACT_SELL   = 3'd1,
    ACT_CANCEL = 3'd2,
    ACT_MODIFY = 3'd3,
    ACT_PRINT  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    KIND_TRADE    = 3'd0,
    KIND_SELL_LVL = 3'd1,
    KIND_BUY_LVL  = 3'd2,
    KIND_END      = 3'd3,
    KIND_REJECT   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_SETVOL,
    CMD_CLRIDX,
    CMD_CLRNUM
  } cmd_op_t;

  typedef enum logic [1:0] {
    SCAN_ID,
    SCAN_MATCH,
    SCAN_LEVEL
  } scan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ID_SCAN,
    ST_ID_ACT,
    ST_MATCH_SCAN,
    ST_MATCH_ACT,
    ST_FREE_SCAN,
    ST_FREE_ACT,
    ST_LVL_SCAN,
    ST_LVL_ACT,
    ST_FINISH
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic             side;
    logic [PRC_W-1:0] price;
    logic [VOL_W-1:0] vol;
    logic [NUM_W-1:0] num;
    logic [ARR_W-1:0] arr;
    scan_t            mode;
    logic [PRC_W-1:0] prev;
    logic             have_prev;
  } cmd_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [PRC_W-1:0] price;
    logic [ARR_W-1:0] arr;
    logic [VOL_W-1:0] vol;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] sum;
    logic             fhit;
    logic [IDX_W-1:0] fidx;
  } token_t;

  typedef struct packed {
    kind_t            kind;
    logic [NUM_W-1:0] rn;
    logic [PRC_W-1:0] rp;
    logic [NUM_W-1:0] inum;
    logic [PRC_W-1:0] ip;
    logic [PRC_W-1:0] lp;
    logic [SUM_W-1:0] q;
  } result_t;

endpackage

// File: sv/lobm_cell.sv
module lobm_cell
  import lobm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  token_t tok_in,
  output token_t tok_out_r
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             valid_r;
  logic             side_r;
  logic [PRC_W-1:0] price_r;
  logic [VOL_W-1:0] vol_r;
  logic [NUM_W-1:0] num_r;
  logic [ARR_W-1:0] arr_r;
  token_t           tok_nxt;
  logic             ok;
  logic             better;
  logic [SUM_W:0]   sum_wide;

  // hold the slot and apply broadcast commands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_WRITE:  if (cmd.idx == MY_IDX) valid_r <= 1'b1;
        CMD_CLRIDX: if (cmd.idx == MY_IDX) valid_r <= 1'b0;
        CMD_CLRNUM: if (valid_r && num_r == cmd.num) valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_WRITE && cmd.idx == MY_IDX) begin
      side_r  <= cmd.side;
      price_r <= cmd.price;
      vol_r   <= cmd.vol;
      num_r   <= cmd.num;
      arr_r   <= cmd.arr;
    end else if (cmd.op == CMD_SETVOL && cmd.idx == MY_IDX) begin
      vol_r <= cmd.vol;
    end
  end

  // fold this slot into the passing token
  always_comb begin
    tok_nxt  = tok_in;
    ok       = 1'b0;
    better   = 1'b0;
    sum_wide = {1'b0, tok_in.sum} + (SUM_W + 1)'(vol_r);
    case (cmd.mode)
      SCAN_ID: begin
        if (!tok_in.hit && valid_r && num_r == cmd.num) begin
          tok_nxt.hit = 1'b1;
          tok_nxt.idx = MY_IDX;
        end
        if (!tok_in.fhit && !valid_r) begin
          tok_nxt.fhit = 1'b1;
          tok_nxt.fidx = MY_IDX;
        end
      end
      SCAN_MATCH: begin
        ok = valid_r && (side_r != cmd.side) &&
             (cmd.side ? (price_r >= cmd.price) : (price_r <= cmd.price));
        if (!tok_in.hit) begin
          better = 1'b1;
        end else if (price_r == tok_in.price) begin
          better = arr_r < tok_in.arr;
        end else begin
          better = cmd.side ? (price_r > tok_in.price) : (price_r < tok_in.price);
        end
        if (ok && better) begin
          tok_nxt.hit   = 1'b1;
          tok_nxt.idx   = MY_IDX;
          tok_nxt.price = price_r;
          tok_nxt.arr   = arr_r;
          tok_nxt.vol   = vol_r;
          tok_nxt.num   = num_r;
        end
      end
      SCAN_LEVEL: begin
        ok = valid_r && (side_r == cmd.side) && (!cmd.have_prev || price_r < cmd.prev);
        if (ok) begin
          if (!tok_in.hit || price_r > tok_in.price) begin
            tok_nxt.hit   = 1'b1;
            tok_nxt.price = price_r;
            tok_nxt.sum   = SUM_W'(vol_r);
          end else if (price_r == tok_in.price) begin
            tok_nxt.sum = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // advance the token one cell per cycle
  always_ff @(posedge clk) begin
    tok_out_r <= tok_nxt;
  end

endmodule

// File: sv/lobm_ctrl.sv
module lobm_ctrl
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_action,
  input  logic             in_immediate_or_cancel,
  input  logic             in_new_side,
  input  logic [PRC_W-1:0] in_limit_price,
  input  logic [VOL_W-1:0] in_quantity_in,
  input  logic [NUM_W-1:0] in_order_number,
  input  token_t           tok_end,
  output cmd_t             cmd,
  output logic             out_valid_r,
  output result_t          out_res_r,
  output logic             out_last_r
);

  localparam int CW = $clog2(BOOK_DEPTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(BOOK_DEPTH - 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [2:0]       act_r, act_nxt;
  logic             ioc_r, ioc_nxt;
  logic             side_r, side_nxt;
  logic             nside_r, nside_nxt;
  logic [PRC_W-1:0] price_r, price_nxt;
  logic [VOL_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [ARR_W-1:0] arr_ctr_r, arr_ctr_nxt;
  logic [PRC_W-1:0] prev_r, prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  result_t          pend_r;
  logic             pend_vld_r;
  logic             emit;
  result_t          emit_res;

  assign busy = (state_r != ST_IDLE);

  // sequencer: next state, cell commands and results
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    ioc_nxt       = ioc_r;
    side_nxt      = side_r;
    nside_nxt     = nside_r;
    price_nxt     = price_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    arr_ctr_nxt   = arr_ctr_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    emit          = 1'b0;
    emit_res      = '{kind: KIND_REJECT, default: '0};

    cmd           = '0;
    cmd.op        = CMD_NOP;
    cmd.side      = side_r;
    cmd.price     = price_r;
    cmd.vol       = rem_r;
    cmd.num       = num_r;
    cmd.arr       = arr_ctr_r;
    cmd.prev      = prev_r;
    cmd.have_prev = have_prev_r;
    cmd.mode      = SCAN_ID;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          ioc_nxt   = in_immediate_or_cancel;
          nside_nxt = in_new_side;
          side_nxt  = in_action[0];
          price_nxt = in_limit_price;
          rem_nxt   = in_quantity_in;
          num_nxt   = in_order_number;
          cnt_nxt   = '0;
          case (in_action)
            ACT_BUY, ACT_SELL, ACT_MODIFY: begin
              if (in_limit_price == '0 || in_quantity_in == '0) begin
                emit      = 1'b1;
                state_nxt = ST_FINISH;
              end else begin
                state_nxt = ST_ID_SCAN;
              end
            end
            ACT_CANCEL: begin
              cmd.op  = CMD_CLRNUM;
              cmd.num = in_order_number;
            end
            ACT_PRINT: begin
              side_nxt      = 1'b1;
              have_prev_nxt = 1'b0;
              state_nxt     = ST_LVL_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_ID_SCAN, ST_FREE_SCAN, ST_MATCH_SCAN, ST_LVL_SCAN: begin
        if (state_r == ST_MATCH_SCAN) cmd.mode = SCAN_MATCH;
        if (state_r == ST_LVL_SCAN) cmd.mode = SCAN_LEVEL;
        if (cnt_r == CNT_LAST) begin
          case (state_r)
            ST_ID_SCAN:    state_nxt = ST_ID_ACT;
            ST_FREE_SCAN:  state_nxt = ST_FREE_ACT;
            ST_MATCH_SCAN: state_nxt = ST_MATCH_ACT;
            default:       state_nxt = ST_LVL_ACT;
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ID_ACT: begin
        cnt_nxt = '0;
        if (act_r == ACT_MODIFY) begin
          if (tok_end.hit) begin
            cmd.op    = CMD_CLRIDX;
            cmd.idx   = tok_end.idx;
            side_nxt  = nside_r;
            ioc_nxt   = 1'b0;
            state_nxt = ST_MATCH_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else if (tok_end.hit) begin
          emit      = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_MATCH_SCAN;
        end
      end
      ST_MATCH_ACT: begin
        cnt_nxt = '0;
        if (tok_end.hit) begin
          emit          = 1'b1;
          emit_res.kind = KIND_TRADE;
          emit_res.rn   = tok_end.num;
          emit_res.rp   = tok_end.price;
          emit_res.inum = num_r;
          emit_res.ip   = price_r;
          if (rem_r >= tok_end.vol) begin
            emit_res.q = SUM_W'(tok_end.vol);
            cmd.op     = CMD_CLRIDX;
            cmd.idx    = tok_end.idx;
            rem_nxt    = rem_r - tok_end.vol;
            state_nxt  = (rem_r == tok_end.vol) ? ST_FINISH : ST_MATCH_SCAN;
          end else begin
            emit_res.q = SUM_W'(rem_r);
            cmd.op     = CMD_SETVOL;
            cmd.idx    = tok_end.idx;
            cmd.vol    = tok_end.vol - rem_r;
            state_nxt  = ST_FINISH;
          end
        end else begin
          state_nxt = ioc_r ? ST_FINISH : ST_FREE_SCAN;
        end
      end
      ST_FREE_ACT: begin
        state_nxt = ST_FINISH;
        if (tok_end.fhit) begin
          cmd.op      = CMD_WRITE;
          cmd.idx     = tok_end.fidx;
          arr_ctr_nxt = arr_ctr_r + 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      ST_LVL_ACT: begin
        cnt_nxt = '0;
        if (tok_end.hit) begin
          emit          = 1'b1;
          emit_res.kind = side_r ? KIND_SELL_LVL : KIND_BUY_LVL;
          emit_res.lp   = tok_end.price;
          emit_res.q    = tok_end.sum;
          prev_nxt      = tok_end.price;
          have_prev_nxt = 1'b1;
          state_nxt     = ST_LVL_SCAN;
        end else if (side_r) begin
          side_nxt      = 1'b0;
          have_prev_nxt = 1'b0;
          state_nxt     = ST_LVL_SCAN;
        end else begin
          emit          = 1'b1;
          emit_res.kind = KIND_END;
          state_nxt     = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      arr_ctr_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      arr_ctr_r   <= arr_ctr_nxt;
      out_valid_r <= 1'b0;
      // hold one result back so the final beat can carry last
      if (emit) begin
        pend_vld_r  <= 1'b1;
        out_valid_r <= pend_vld_r;
      end else if (state_r == ST_FINISH) begin
        pend_vld_r  <= 1'b0;
        out_valid_r <= pend_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    ioc_r       <= ioc_nxt;
    side_r      <= side_nxt;
    nside_r     <= nside_nxt;
    price_r     <= price_nxt;
    rem_r       <= rem_nxt;
    num_r       <= num_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    if (emit) begin
      pend_r     <= emit_res;
      out_res_r  <= pend_r;
      out_last_r <= 1'b0;
    end else if (state_r == ST_FINISH) begin
      out_res_r  <= pend_r;
      out_last_r <= 1'b1;
    end
  end

endmodule

// File: sv/limit_order_book_matcher.sv
// Price-then-arrival order book of BOOK_DEPTH slots held in a chain of cells;
// a scan token walks one cell per cycle, so every book search is a full pass
// over all cells followed by a decision state. A cancel never raises busy.
// Results leave as single-cycle beats on out_valid with out_last on the final
// beat of an item; the receiver cannot stall, so every beat must be taken when
// shown. busy drops in the cycle that shows the last beat of an item.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_action,
  input  logic                in_immediate_or_cancel,
  input  logic                in_new_side,
  input  logic [PRC_W-1:0]    in_limit_price,
  input  logic [VOL_W-1:0]    in_quantity_in,
  input  logic [NUM_W-1:0]    in_order_number,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [NUM_W-1:0]    out_resting_number,
  output logic [PRC_W-1:0]    out_resting_price,
  output logic [NUM_W-1:0]    out_incoming_number,
  output logic [PRC_W-1:0]    out_incoming_price,
  output logic [PRC_W-1:0]    out_level_price,
  output logic [SUM_W-1:0]    out_quantity_out,
  output logic                out_last
);

  cmd_t    cmd;
  token_t  tok [BOOK_DEPTH+1];
  result_t res;

  // empty token enters the head of the chain
  assign tok[0] = '0;

  for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
    lobm_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .tok_in   (tok[g]),
      .tok_out_r(tok[g+1])
    );
  end

  lobm_ctrl #(.BOOK_DEPTH(BOOK_DEPTH)) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_action             (in_action),
    .in_immediate_or_cancel(in_immediate_or_cancel),
    .in_new_side           (in_new_side),
    .in_limit_price        (in_limit_price),
    .in_quantity_in        (in_quantity_in),
    .in_order_number       (in_order_number),
    .tok_end               (tok[BOOK_DEPTH]),
    .cmd                   (cmd),
    .out_valid_r           (out_valid),
    .out_res_r             (res),
    .out_last_r            (out_last)
  );

  assign out_kind            = res.kind;
  assign out_resting_number  = res.rn;
  assign out_resting_price   = res.rp;
  assign out_incoming_number = res.inum;
  assign out_incoming_price  = res.ip;
  assign out_level_price     = res.lp;
  assign out_quantity_out    = res.q;

endmodule

// File: dv/tb_limit_order_book_matcher.sv
`timescale 1ns / 100ps

module tb_limit_order_book_matcher;
  import lobm_pkg::*;

  localparam int DEPTH     = 32;
  localparam int WDOG_MAX  = 20000;
  localparam int TAIL_CYC  = 200;
  localparam int N_RANDOM  = 320;

  // one order-book command, or a marker that holds the sender until drained
  typedef struct {
    logic        drain;
    logic [2:0]  act;
    logic        ioc;
    logic        nside;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] num;
  } order_cmd_t;

  typedef struct {
    result_t r;
    logic    last;
  } book_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  in_action = '0;
  logic        in_immediate_or_cancel = 1'b0;
  logic        in_new_side = 1'b0;
  logic [31:0] in_limit_price = '0;
  logic [31:0] in_quantity_in = '0;
  logic [31:0] in_order_number = '0;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [31:0] out_resting_number, out_resting_price;
  logic [31:0] out_incoming_number, out_incoming_price;
  logic [31:0] out_level_price;
  logic [35:0] out_quantity_out;
  logic        out_last;

  limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) u_dut (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_immediate_or_cancel, .in_new_side,
    .in_limit_price, .in_quantity_in, .in_order_number,
    .out_valid, .out_kind, .out_resting_number, .out_resting_price,
    .out_incoming_number, .out_incoming_price, .out_level_price,
    .out_quantity_out, .out_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow book
  logic        bk_valid [DEPTH];
  logic        bk_side  [DEPTH];
  logic [31:0] bk_price [DEPTH];
  logic [31:0] bk_vol   [DEPTH];
  logic [31:0] bk_num   [DEPTH];
  logic [39:0] bk_arr   [DEPTH];
  logic [39:0] arrival_ctr;

  order_cmd_t pending_cmds[$];
  book_beat_t expected_beats[$];
  book_beat_t step_beats[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  logic acc_q = 1'b0;
  int  gap_left = 0;
  logic no_gap_mode = 1'b0;

  task automatic emit(kind_t k, logic [31:0] rn, logic [31:0] rp, logic [31:0] inn,
                      logic [31:0] ip, logic [31:0] lp, logic [35:0] q);
    book_beat_t b;
    b.r.kind = k; b.r.rn = rn; b.r.rp = rp; b.r.inum = inn;
    b.r.ip = ip; b.r.lp = lp; b.r.q = q; b.last = 1'b0;
    step_beats.push_back(b);
  endtask

  function automatic int find_order(logic [31:0] num);
    for (int i = 0; i < DEPTH; i++)
      if (bk_valid[i] && bk_num[i] == num) return i;
    return -1;
  endfunction

  // match against the other side, then rest or drop the remainder
  task automatic match_and_rest(logic side, logic [31:0] price, logic [31:0] vol,
                                logic [31:0] num, logic ioc);
    logic [31:0] rem;
    int best;
    logic ok, better;
    rem = vol;
    while (rem != 0) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[i] || bk_side[i] == side) continue;
        ok = (side == 1'b0) ? (bk_price[i] <= price) : (bk_price[i] >= price);
        if (!ok) continue;
        if (best < 0) better = 1'b1;
        else if (bk_price[i] == bk_price[best]) better = bk_arr[i] < bk_arr[best];
        else better = (side == 1'b0) ? (bk_price[i] < bk_price[best])
                                     : (bk_price[i] > bk_price[best]);
        if (better) best = i;
      end
      if (best < 0) break;
      if (rem >= bk_vol[best]) begin
        emit(KIND_TRADE, bk_num[best], bk_price[best], num, price, '0, {4'd0, bk_vol[best]});
        rem -= bk_vol[best];
        bk_valid[best] = 1'b0;
      end else begin
        emit(KIND_TRADE, bk_num[best], bk_price[best], num, price, '0, {4'd0, rem});
        bk_vol[best] -= rem;
        rem = 0;
      end
    end
    if (rem == 0 || ioc) return;
    for (int i = 0; i < DEPTH; i++) begin
      if (!bk_valid[i]) begin
        bk_valid[i] = 1'b1; bk_side[i] = side; bk_price[i] = price;
        bk_vol[i] = rem; bk_num[i] = num; bk_arr[i] = arrival_ctr;
        arrival_ctr = arrival_ctr + 40'd1;
        return;
      end
    end
    emit(KIND_REJECT, '0, '0, '0, '0, '0, '0);
  endtask

  // aggregated levels of one side, descending price
  task automatic list_levels(logic side, kind_t k);
    logic have_prev, found;
    logic [31:0] prev, top;
    logic [37:0] sum;
    have_prev = 1'b0;
    prev = 0;
    forever begin
      found = 1'b0;
      top = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[i] || bk_side[i] != side) continue;
        if (have_prev && bk_price[i] >= prev) continue;
        if (!found || bk_price[i] > top) begin
          top = bk_price[i];
          found = 1'b1;
        end
      end
      if (!found) return;
      sum = 0;
      for (int i = 0; i < DEPTH; i++)
        if (bk_valid[i] && bk_side[i] == side && bk_price[i] == top) begin
          sum += bk_vol[i];
          if (sum > 38'hF_FFFF_FFFF) sum = 38'hF_FFFF_FFFF;
        end
      emit(k, '0, '0, '0, '0, top, sum[35:0]);
      prev = top;
      have_prev = 1'b1;
    end
  endtask

  task automatic predict_book(order_cmd_t c);
    int s;
    step_beats.delete();
    case (c.act)
      ACT_BUY, ACT_SELL: begin
        if (c.price == 0 || c.qty == 0 || find_order(c.num) >= 0)
          emit(KIND_REJECT, '0, '0, '0, '0, '0, '0);
        else
          match_and_rest(c.act[0], c.price, c.qty, c.num, c.ioc);
      end
      ACT_CANCEL: begin
        for (int i = 0; i < DEPTH; i++)
          if (bk_valid[i] && bk_num[i] == c.num) bk_valid[i] = 1'b0;
      end
      ACT_MODIFY: begin
        if (c.price == 0 || c.qty == 0) begin
          emit(KIND_REJECT, '0, '0, '0, '0, '0, '0);
        end else begin
          s = find_order(c.num);
          if (s >= 0) begin
            bk_valid[s] = 1'b0;
            match_and_rest(c.nside, c.price, c.qty, c.num, 1'b0);
          end
        end
      end
      ACT_PRINT: begin
        list_levels(1'b1, KIND_SELL_LVL);
        list_levels(1'b0, KIND_BUY_LVL);
        emit(KIND_END, '0, '0, '0, '0, '0, '0);
      end
      default: ;
    endcase
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endtask

  function automatic order_cmd_t mk_cmd(logic [2:0] act, logic ioc, logic nside,
                                        logic [31:0] price, logic [31:0] qty,
                                        logic [31:0] num);
    order_cmd_t c;
    c.drain = 1'b0; c.act = act; c.ioc = ioc; c.nside = nside;
    c.price = price; c.qty = qty; c.num = num;
    return c;
  endfunction

  function automatic order_cmd_t drain_mark();
    order_cmd_t c;
    c = mk_cmd(3'd0, 1'b0, 1'b0, '0, '0, '0);
    c.drain = 1'b1;
    return c;
  endfunction

  function automatic logic [31:0] rnd_price();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 32'd0;
    if (p < 9) return $urandom;
    if (p < 11) return 32'hFFFF_FFFF;
    return $urandom_range(95, 105);
  endfunction

  function automatic logic [31:0] rnd_qty();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 32'd0;
    if (p < 9) return $urandom;
    return $urandom_range(1, 20);
  endfunction

  function automatic logic [31:0] rnd_num();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return $urandom_range(1, 40);
  endfunction

  function automatic order_cmd_t rnd_cmd();
    int p;
    logic [2:0] a;
    p = $urandom_range(0, 99);
    if (p < 45) a = 3'($urandom_range(0, 1));
    else if (p < 60) a = ACT_CANCEL;
    else if (p < 78) a = ACT_MODIFY;
    else if (p < 92) a = ACT_PRINT;
    else a = 3'($urandom_range(5, 7));
    return mk_cmd(a, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                  rnd_price(), rnd_qty(), rnd_num());
  endfunction

  // fill the book with huge sells at one price, overflow it, print, sweep
  task automatic queue_flood();
    logic [31:0] px;
    px = 32'hFFFF_FFF0 - $urandom_range(0, 3);
    for (int i = 0; i < DEPTH + 1; i++)
      pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, px, 32'hFFFF_FFFF, 32'd1000 + i));
    pending_cmds.push_back(mk_cmd(ACT_PRINT, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_BUY, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2000));
    pending_cmds.push_back(mk_cmd(ACT_BUY, 0, 1, px, 32'hFFFF_FFFF, 32'd2001));
    for (int i = 0; i < DEPTH + 1; i++)
      pending_cmds.push_back(mk_cmd(ACT_CANCEL, 0, 0, 0, 0, 32'd1000 + i));
    pending_cmds.push_back(drain_mark());
  endtask

  // driver: change inputs on the falling edge
  always @(negedge clk) begin
    order_cmd_t c;
    if (rst_n) begin
      if (start && !acc_q) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].drain) begin
        if (expected_beats.size() == 0 && !busy) void'(pending_cmds.pop_front());
        start <= 1'b0;
      end else begin
        c = pending_cmds.pop_front();
        in_action <= c.act;
        in_immediate_or_cancel <= c.ioc;
        in_new_side <= c.nside;
        in_limit_price <= c.price;
        in_quantity_in <= c.qty;
        in_order_number <= c.num;
        start <= 1'b1;
        if ($urandom_range(0, 29) == 0) no_gap_mode = ~no_gap_mode;
        gap_left = no_gap_mode ? 0 : $urandom_range(0, 9);
      end
    end
  end

  // monitor: take input beats into the predictor, check result beats
  always @(posedge clk) begin
    order_cmd_t c;
    book_beat_t e;
    logic took;
    took = rst_n && start && !busy;
    acc_q <= took;
    if (took) begin
      c = mk_cmd(in_action, in_immediate_or_cancel, in_new_side,
                 in_limit_price, in_quantity_in, in_order_number);
      predict_book(c);
    end
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat kind=%0d", out_kind);
      end else begin
        e = expected_beats.pop_front();
        if (out_kind !== e.r.kind || out_resting_number !== e.r.rn ||
            out_resting_price !== e.r.rp || out_incoming_number !== e.r.inum ||
            out_incoming_price !== e.r.ip || out_level_price !== e.r.lp ||
            out_quantity_out !== e.r.q || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp k=%0d rn=%0d rp=%0d in=%0d ip=%0d lp=%0d q=%0d l=%0b",
                      " | got k=%0d rn=%0d rp=%0d in=%0d ip=%0d lp=%0d q=%0d l=%0b"},
                     e.r.kind, e.r.rn, e.r.rp, e.r.inum, e.r.ip, e.r.lp, e.r.q, e.last,
                     out_kind, out_resting_number, out_resting_price,
                     out_incoming_number, out_incoming_price, out_level_price,
                     out_quantity_out, out_last);
        end
      end
    end
    // watchdog on cycles with no beat moving
    if (took || (rst_n && out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      bk_valid[i] = 1'b0; bk_side[i] = 1'b0; bk_price[i] = '0;
      bk_vol[i] = '0; bk_num[i] = '0; bk_arr[i] = '0;
    end
    arrival_ctr = '0;

    // directed: rejects, empty print, unused actions, extremes, ties, modify
    pending_cmds.push_back(mk_cmd(ACT_PRINT, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_BUY, 0, 0, 0, 5, 1));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, 10, 0, 2));
    pending_cmds.push_back(mk_cmd(ACT_MODIFY, 0, 0, 0, 5, 1));
    pending_cmds.push_back(mk_cmd(3'd5, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(3'd7, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, 100, 10, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, 100, 7, 0));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, 99, 3, 3));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, 1, 3, 4));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, 5, 3, 0));
    pending_cmds.push_back(mk_cmd(ACT_BUY, 0, 0, 32'hFFFF_FFFF, 1, 5));
    pending_cmds.push_back(mk_cmd(ACT_PRINT, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_BUY, 1, 0, 100, 15, 6));
    pending_cmds.push_back(mk_cmd(ACT_BUY, 0, 0, 100, 20, 7));
    pending_cmds.push_back(mk_cmd(ACT_MODIFY, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7));
    pending_cmds.push_back(mk_cmd(ACT_MODIFY, 0, 0, 50, 4, 77));
    pending_cmds.push_back(mk_cmd(ACT_CANCEL, 0, 0, 0, 0, 77));
    pending_cmds.push_back(mk_cmd(ACT_BUY, 0, 0, 1, 2, 8));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 0, 0, 1, 32'hFFFF_FFFF, 8));
    pending_cmds.push_back(mk_cmd(ACT_SELL, 1, 0, 1, 1, 9));
    pending_cmds.push_back(mk_cmd(ACT_CANCEL, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(ACT_PRINT, 0, 0, 0, 0, 0));
    pending_cmds.push_back(drain_mark());

    // random: mostly plausible orders on a small id and price range
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 75) queue_flood();
      if (n % 100 == 99) pending_cmds.push_back(drain_mark());
      pending_cmds.push_back(rnd_cmd());
    end
    pending_cmds.push_back(mk_cmd(ACT_PRINT, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for every beat to go in and come back, then let the tail settle
    wait (pending_cmds.size() == 0 && !start && expected_beats.size() == 0 && !busy);
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
sv/lobm_pkg.sv
sv/lobm_cell.sv
sv/lobm_ctrl.sv
sv/limit_order_book_matcher.sv
dv/tb_limit_order_book_matcher.sv
